>>> rtl/gdps_pkg.sv
// Shared types and constants for the grid density power spectrum block.
// No dependencies.
package gdps_pkg;

  localparam logic [31:0] Inv2PiQ32   = 32'd683565276;
  localparam logic [31:0] CordicInit  = 32'd652032874;
  localparam int          CordicSteps = 30;
  localparam logic [62:0] Lim         = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] OutMax      = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_NORM_SCALE   = 3'd1,
    REG_CELL_SIZE_0  = 3'd2,
    REG_CELL_SIZE_1  = 3'd3,
    REG_CELL_SIZE_2  = 3'd4
  } reg_idx_e;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [11:0] cell_index;
    logic [31:0] weight;
    logic [31:0] freq_0;
    logic [31:0] freq_1;
    logic [31:0] freq_2;
  } in_item_t;

  typedef struct packed {
    logic [62:0] spectrum;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // CORDIC step angles in 2^-32 turns
  function automatic logic [29:0] turn_atan(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;
        5'd2: r = 30'd167458907;  5'd3: r = 30'd85004756;
        5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
        5'd6: r = 30'd10679838;   5'd7: r = 30'd5340245;
        5'd8: r = 30'd2670163;    5'd9: r = 30'd1335087;
        5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
        5'd12: r = 30'd166886;    5'd13: r = 30'd83443;
        5'd14: r = 30'd41722;     5'd15: r = 30'd20861;
        5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
        5'd18: r = 30'd2608;      5'd19: r = 30'd1304;
        5'd20: r = 30'd652;       5'd21: r = 30'd326;
        5'd22: r = 30'd163;       5'd23: r = 30'd81;
        5'd24: r = 30'd41;        5'd25: r = 30'd20;
        5'd26: r = 30'd10;        5'd27: r = 30'd5;
        5'd28: r = 30'd3;         5'd29: r = 30'd1;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/gdps_if.sv
// Valid/ready channel interface carrying a payload of type T.
// Used for the input, output and configuration channels.
interface gdps_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/gdps_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module gdps_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/grid_density_power_spectrum.sv
// Grid density power spectrum: one valid/ready input channel (weight writes and
// evaluations), one result channel, one configuration write channel.
//
// A write item (func 0) stores one weight at the edge where it is transferred
// (ignored if cell_index is out of range); writes can follow back to back and
// give no result. An evaluate item (func 1) builds the axis integral table
// (DIMS*GRID_SIDE entries; each needs two 30-step CORDIC runs and two 64-bit
// restoring divisions, skipped when that frequency is zero), then walks every
// grid cell: complex products per dimension through one shared 32x32 multiplier,
// then weighting, and then the final formula. One item is worked on at a
// time.
//
// After reset the block first clears the weight memory, one entry per cycle
// (GRID_SIDE^DIMS entries, 256 by default); configuration writes are taken
// meanwhile. The result sits in an output register; while the receiver stalls
// the block holds it and takes no new item until it is transferred.
// Registers reset to sample_count 1, norm_scale 1.0, cell sizes 1.0.
module grid_density_power_spectrum
  import gdps_pkg::*;
#(
  parameter int DIMS      = 2,
  parameter int GRID_SIDE = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gdps_if.sink   in_if,
  gdps_if.source out_if,
  gdps_if.sink   cfg_if
);
  localparam int Cells  = GRID_SIDE ** DIMS;
  localparam int CellW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int AxisN  = DIMS * GRID_SIDE;
  localparam int AxisW  = (AxisN > 1) ? $clog2(AxisN) : 1;
  localparam int ColW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int DimW   = 2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_AX_START, S_AX_MUL0, S_AX_MUL1, S_AX_ANG,
    S_CORDIC, S_CORDIC_FIN, S_DIV_SETUP, S_DIV, S_DIV_DONE, S_AX_WRITE,
    S_CELL_RD, S_CELL_WAIT, S_CELL_MUL, S_CELL_COMB, S_CELL_WT, S_CELL_ACC,
    S_FIN_MUL, S_FIN_STEP, S_OUT
  } state_e;

  // ---------------- configuration ----------------
  logic [15:0] sample_count_q;
  logic [31:0] norm_scale_q;
  logic [31:0] cell_size_q [3];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= 16'd1;
      norm_scale_q   <= 32'd1073741824;
      cell_size_q[0] <= 32'd65536;
      cell_size_q[1] <= 32'd65536;
      cell_size_q[2] <= 32'd65536;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        REG_SAMPLE_COUNT: sample_count_q <= cfg_if.data.data[15:0];
        REG_NORM_SCALE:   norm_scale_q   <= cfg_if.data.data;
        REG_CELL_SIZE_0:  cell_size_q[0] <= cfg_if.data.data;
        REG_CELL_SIZE_1:  cell_size_q[1] <= cfg_if.data.data;
        REG_CELL_SIZE_2:  cell_size_q[2] <= cfg_if.data.data;
        default: ;
      endcase
    end
  end

  // ---------------- shared multiplier: 64x64 unsigned in 4 partial products ----
  // ma_q/mb_q operands, 32x32 partial products summed into prod_q (128 bit)
  logic [63:0]  ma_q, mb_q;
  logic [127:0] prod_q;
  logic [1:0]   mph_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  always_comb begin
    pa = mph_q[0] ? ma_q[63:32] : ma_q[31:0];
    pb = mph_q[1] ? mb_q[63:32] : mb_q[31:0];
  end
  assign pp = {32'd0, pa} * {32'd0, pb};

  // ---------------- memories ----------------
  logic             wg_we;
  logic [CellW-1:0] wg_addr;
  logic [31:0]      wg_wdata, wg_rdata;
  gdps_ram #(.Width(32), .Depth(Cells)) u_wgrid (
    .clk_i, .we_i(wg_we), .addr_i(wg_addr), .wdata_i(wg_wdata), .rdata_o(wg_rdata)
  );

  logic              ax_we;
  logic [AxisW-1:0]  ax_addr;
  logic [127:0]      ax_wdata, ax_rdata;
  gdps_ram #(.Width(128), .Depth(AxisN)) u_axis (
    .clk_i, .we_i(ax_we), .addr_i(ax_addr), .wdata_i(ax_wdata), .rdata_o(ax_rdata)
  );

  // ---------------- sequencer registers ----------------
  state_e           state_q;
  in_item_t         item_q;
  logic [CellW:0]   clr_q;
  logic [DimW-1:0]  dim_q;
  logic [ColW:0]    col_q;
  logic             bsel_q;      // 0: lower bound b0, 1: upper b1
  logic [63:0]      f_q, b0_q;
  logic [31:0]      ang_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [4:0]       cit_q;
  logic signed [33:0] c0_q, s0_q, c1_q, s1_q;
  logic             dsel_q;      // 0: cosine integral, 1: sine integral
  logic [63:0]      dnum_q, dq_q, drem_q;
  logic [31:0]      dden_q;
  logic             dneg_q;
  logic [6:0]       dcnt_q;
  logic signed [63:0] ci_q, si_q;
  logic [CellW:0]   cell_q;
  logic [ColW-1:0]  dig_q [3];   // column of the current cell along each dimension
  logic [ColW-1:0]  dig_nx [3];
  logic signed [63:0] pr_q, pi_q, ar_q, ai_q;
  logic [1:0]       term_q;
  logic signed [63:0] t_q [4];
  logic signed [63:0] rs_q, is_q;
  logic [2:0]       fstep_q;
  logic [63:0]      fv_q, fsq_q;
  logic             ovf_q;
  logic             mneg_q;
  logic             wt_im_q;
  logic [31:0]      wgt_q;
  logic             ovalid_q;
  out_item_t        odata_q;

  logic signed [31:0] freq_sel;
  logic [31:0]        cs_sel;
  always_comb begin
    case (dim_q)
      2'd0:    begin freq_sel = item_q.freq_0; cs_sel = cell_size_q[0]; end
      2'd1:    begin freq_sel = item_q.freq_1; cs_sel = cell_size_q[1]; end
      default: begin freq_sel = item_q.freq_2; cs_sel = cell_size_q[2]; end
    endcase
  end

  // next cell's columns: dimension 0 fastest, carry into the next
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = 0; d < 3; d++) begin
      dig_nx[d] = dig_q[d];
      if (carry) begin
        if (dig_q[d] == ColW'(GRID_SIDE - 1)) begin
          dig_nx[d] = '0;
        end else begin
          dig_nx[d] = dig_q[d] + 1'b1;
          carry = 1'b0;
        end
      end
    end
  end

  // unsigned product magnitude clamp of p >> s to lim; o flags the clamp
  function automatic logic [62:0] clamp_shr(input logic [127:0] p, input logic [6:0] s,
                                            input logic [62:0] lim, output logic o);
    logic [127:0] r;
    begin
      r = p >> s;
      o = (r[127:63] != '0) || (r[62:0] > lim);
      return o ? lim : r[62:0];
    end
  endfunction

  function automatic logic [63:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [64:0] r;
    begin
      r = {a[63], a} + {b[63], b};
      if (r > $signed({2'b0, Lim})) return {1'b0, Lim};
      if (r < -$signed({2'b0, Lim})) return -{1'b0, Lim};
      return r[63:0];
    end
  endfunction

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  logic [62:0]       cl_q32, cl_q16;
  logic              cl_ov32, cl_ov16;
  always_comb begin
    cl_q32 = clamp_shr(prod_q, 7'd32, Lim, cl_ov32);
    cl_q16 = clamp_shr(prod_q, 7'd16, Lim, cl_ov16);
  end

  // final-formula clamp of prod_q >> s to OutMax
  logic [62:0] clf;
  logic        clf_ov;
  logic [6:0]  fshift;
  always_comb begin
    fshift = (fstep_q == 3'd0 || fstep_q == 3'd1) ? 7'd32 :
             (fstep_q == 3'd4 || fstep_q == 3'd5) ? 7'd30 : 7'd0;
    clf = clamp_shr(prod_q, fshift, OutMax, clf_ov);
  end

  // cordic step
  logic signed [33:0] cdx, cdy;
  assign cdx = cy_q >>> cit_q;
  assign cdy = cx_q >>> cit_q;

  logic [63:0] dtrial;
  assign dtrial = {drem_q[62:0], dnum_q[63]};

  logic in_rdy;
  assign in_rdy = (state_q == S_IDLE) && !ovalid_q;
  assign in_if.ready = in_rdy;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  // memory port drive
  always_comb begin
    wg_we = 1'b0; wg_addr = cell_q[CellW-1:0]; wg_wdata = item_q.weight;
    if (state_q == S_CLEAR) begin
      wg_we = 1'b1; wg_addr = clr_q[CellW-1:0]; wg_wdata = '0;
    end else if (in_rdy && in_if.valid && in_if.data.func == FUNC_WRITE &&
                 {1'b0, in_if.data.cell_index} < 13'(Cells)) begin
      wg_we = 1'b1; wg_addr = in_if.data.cell_index[CellW-1:0];
      wg_wdata = in_if.data.weight;
    end
    ax_we = (state_q == S_AX_WRITE);
    ax_wdata = {ci_q, si_q};
    ax_addr = AxisW'(dim_q * GRID_SIDE + 32'(col_q[ColW-1:0]));
    if (state_q != S_AX_WRITE) begin
      ax_addr = AxisW'(dim_q * GRID_SIDE + 32'(dig_q[dim_q]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      mph_q    <= '0;
    end else begin
      if (ovalid_q && out_if.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (CellW+1)'(Cells - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_rdy && in_if.valid) begin
            item_q <= in_if.data;
            if (in_if.data.func == FUNC_EVAL) begin
              dim_q <= '0; col_q <= '0; state_q <= S_AX_START;
            end
          end
        end
        S_AX_START: begin
          bsel_q <= 1'b0;
          if (freq_sel == 0) begin
            ci_q <= {16'd0, cs_sel, 16'd0}; si_q <= '0; state_q <= S_AX_WRITE;
          end else begin
            // f = w * inv2pi (mod 2^64); b0 = k*cs
            ma_q <= {{32{freq_sel[31]}}, freq_sel};
            mb_q <= {32'd0, Inv2PiQ32};
            mph_q <= '0; prod_q <= '0; state_q <= S_AX_MUL0;
          end
        end
        S_AX_MUL0: begin
          prod_q <= prod_q + (128'(pp) << (32 * (mph_q[0] + mph_q[1])));
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd3) begin
            f_q <= 64'(prod_q + (128'(pp) << 64));
            b0_q <= 64'(col_q[ColW-1:0]) * 64'(cs_sel);
            state_q <= S_AX_MUL1;
          end
        end
        S_AX_MUL1: begin
          ma_q <= f_q;
          mb_q <= bsel_q ? b0_q + 64'(cs_sel) : b0_q;
          mph_q <= '0; prod_q <= '0; state_q <= S_AX_ANG;
        end
        S_AX_ANG: begin
          prod_q <= prod_q + (128'(pp) << (32 * (mph_q[0] + mph_q[1])));
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd3) begin
            // the last partial product only reaches bits 64 and up
            ang_q <= prod_q[63:32];
            cx_q <= 34'(CordicInit); cy_q <= '0; cit_q <= '0;
            cz_q <= $signed({2'b0, prod_q[61:32]});
            state_q <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cz_q[31] == 1'b0) begin
            cx_q <= cx_q - cdx; cy_q <= cy_q + cdy;
            cz_q <= cz_q - $signed({2'b0, turn_atan(cit_q)});
          end else begin
            cx_q <= cx_q + cdx; cy_q <= cy_q - cdy;
            cz_q <= cz_q + $signed({2'b0, turn_atan(cit_q)});
          end
          if (cit_q == 5'(CordicSteps - 1)) state_q <= S_CORDIC_FIN;
          cit_q <= cit_q + 1'b1;
        end
        S_CORDIC_FIN: begin
          logic signed [33:0] co, so;
          case (ang_q[31:30])
            2'd0: begin co = cx_q;  so = cy_q;  end
            2'd1: begin co = -cy_q; so = cx_q;  end
            2'd2: begin co = -cx_q; so = -cy_q; end
            default: begin co = cy_q; so = -cx_q; end
          endcase
          if (!bsel_q) begin
            c0_q <= co; s0_q <= so; bsel_q <= 1'b1; state_q <= S_AX_MUL1;
          end else begin
            c1_q <= co; s1_q <= so; dsel_q <= 1'b0; state_q <= S_DIV_SETUP;
          end
        end
        S_DIV_SETUP: begin
          logic signed [63:0] num;
          num = dsel_q ? (64'(c0_q) - 64'(c1_q)) <<< 18 : (64'(s1_q) - 64'(s0_q)) <<< 18;
          dneg_q <= num[63] ^ freq_sel[31];
          dnum_q <= absv(num);
          dden_q <= freq_sel[31] ? -freq_sel : freq_sel;
          drem_q <= '0; dcnt_q <= '0; state_q <= S_DIV;
        end
        S_DIV: begin
          if (dtrial >= 64'(dden_q)) begin
            drem_q <= dtrial - 64'(dden_q); dq_q <= {dq_q[62:0], 1'b1};
          end else begin
            drem_q <= dtrial; dq_q <= {dq_q[62:0], 1'b0};
          end
          dnum_q <= {dnum_q[62:0], 1'b0};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 7'd63) state_q <= S_DIV_DONE;
        end
        S_DIV_DONE: begin
          if (!dsel_q) begin
            ci_q <= dneg_q ? -dq_q : dq_q; dsel_q <= 1'b1; state_q <= S_DIV_SETUP;
          end else begin
            si_q <= dneg_q ? -dq_q : dq_q; state_q <= S_AX_WRITE;
          end
        end
        S_AX_WRITE: begin
          if (col_q == (ColW+1)'(GRID_SIDE - 1)) begin
            col_q <= '0;
            if (dim_q == DimW'(DIMS - 1)) begin
              dim_q <= '0; cell_q <= '0;
              dig_q[0] <= '0; dig_q[1] <= '0; dig_q[2] <= '0;
              rs_q <= '0; is_q <= '0; state_q <= S_CELL_RD;
              pr_q <= 64'h1_0000_0000; pi_q <= '0;
            end else begin
              dim_q <= dim_q + 1'b1; state_q <= S_AX_START;
            end
          end else begin
            col_q <= col_q + 1'b1; state_q <= S_AX_START;
          end
        end
        S_CELL_RD: state_q <= S_CELL_WAIT;
        S_CELL_WAIT: begin
          ar_q <= ax_rdata[127:64]; ai_q <= ax_rdata[63:0];
          wgt_q <= wg_rdata;
          term_q <= '0; state_q <= S_CELL_MUL;
        end
        S_CELL_MUL: begin
          // operands for term pr*ar, pi*ai, pr*ai, pi*ar
          logic signed [63:0] x, y;
          x = term_q[0] ? pi_q : pr_q;
          y = (term_q == 2'd0 || term_q == 2'd3) ? ar_q : ai_q;
          ma_q <= absv(x); mb_q <= absv(y); mneg_q <= x[63] ^ y[63];
          mph_q <= '0; prod_q <= '0; state_q <= S_CELL_COMB;
          wt_im_q <= 1'b0;
        end
        S_CELL_COMB: begin
          prod_q <= prod_q + (128'(pp) << (32 * (mph_q[0] + mph_q[1])));
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd3) state_q <= S_CELL_WT;
        end
        S_CELL_WT: begin
          logic signed [63:0] smul_res;
          smul_res = mneg_q ? -{1'b0, cl_q32} : {1'b0, cl_q32};
          t_q[term_q] <= smul_res;
          term_q <= term_q + 1'b1;
          if (term_q == 2'd3) begin
            pr_q <= sat_add(t_q[0], -t_q[1]);
            pi_q <= sat_add(t_q[2], smul_res);
            if (dim_q == DimW'(DIMS - 1)) begin
              dim_q <= '0; state_q <= S_CELL_ACC;
            end else begin
              dim_q <= dim_q + 1'b1;
              state_q <= S_CELL_RD;
            end
          end else begin
            state_q <= S_CELL_MUL;
          end
        end
        S_CELL_ACC: begin
          // weight real then imaginary
          ma_q <= absv(wt_im_q ? pi_q : pr_q); mb_q <= {32'd0, wgt_q};
          mneg_q <= wt_im_q ? pi_q[63] : pr_q[63];
          mph_q <= '0; prod_q <= '0; state_q <= S_FIN_MUL; fstep_q <= 3'd7;
        end
        S_FIN_MUL: begin
          prod_q <= prod_q + (128'(pp) << (32 * (mph_q[0] + mph_q[1])));
          mph_q <= mph_q + 1'b1;
          if (mph_q == 2'd3) state_q <= S_FIN_STEP;
        end
        S_FIN_STEP: begin
          if (fstep_q == 3'd7) begin
            logic signed [63:0] smul_res;
            smul_res = mneg_q ? -{1'b0, cl_q16} : {1'b0, cl_q16};
            if (!wt_im_q) begin
              rs_q <= sat_add(rs_q, smul_res); wt_im_q <= 1'b1; state_q <= S_CELL_ACC;
            end else begin
              is_q <= sat_add(is_q, smul_res);
              wt_im_q <= 1'b0;
              if (cell_q == (CellW+1)'(Cells - 1)) begin
                fstep_q <= 3'd0; ovf_q <= 1'b0;
                ma_q <= absv(rs_q); mb_q <= absv(rs_q);
                mph_q <= '0; prod_q <= '0; state_q <= S_FIN_MUL;
              end else begin
                cell_q <= cell_q + 1'b1;
                dig_q <= dig_nx;
                pr_q <= 64'h1_0000_0000; pi_q <= '0;
                state_q <= S_CELL_RD;
              end
            end
          end else begin
            logic [63:0] nv, nx;
            logic        ov;
            ov = ovf_q | clf_ov;
            nv = {1'b0, clf};
            nx = '0;
            unique case (fstep_q) inside
              3'd0: begin fsq_q <= nv; nx = absv(is_q); ma_q <= nx; mb_q <= nx; end
              3'd1: begin
                nv = fsq_q + nv;
                if (nv > {1'b0, OutMax}) begin ov = 1'b1; nv = {1'b0, OutMax}; end
                ma_q <= nv;
                mb_q <= (sample_count_q == 0) ? '0 : 64'(sample_count_q - 1'b1);
              end
              3'd2: begin
                nv = nv + 64'h1_0000_0000;
                if (nv > {1'b0, OutMax}) begin ov = 1'b1; nv = {1'b0, OutMax}; end
                ma_q <= nv; mb_q <= 64'(sample_count_q);
              end
              3'd3, 3'd4: begin ma_q <= nv; mb_q <= 64'(norm_scale_q); end
              default: begin
                ovalid_q <= 1'b1;
                odata_q.spectrum  <= ov ? OutMax : nv[62:0];
                odata_q.saturated <= ov;
              end
            endcase
            ovf_q <= ov;
            if (fstep_q == 3'd5) begin
              state_q <= S_OUT;
            end else begin
              fstep_q <= fstep_q + 1'b1;
              mph_q <= '0; prod_q <= '0; state_q <= S_FIN_MUL;
            end
          end
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
